[sv/tir_pkg.sv]
// Shared constants for the tetrahedron inradius datapath.
package tir_pkg;

	// Default coordinate width in bits (signed fixed point)
	localparam int COORD_WIDTH_DEF = 32;

	// Width of the radius result
	localparam int RADIUS_WIDTH = 32;

	// Faces of a tetrahedron, one square-root lane each
	localparam int NUM_FACES = 4;

endpackage

[sv/tir_sqrt.sv]
// Pipelined floor square root, four lanes side by side, one result bit per stage.
module tir_sqrt
	import tir_pkg::*;
#(
	parameter int RW = 67,
	parameter int PW = 102
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   radicand [NUM_FACES],
	input  logic [PW-1:0]     in_side,
	output logic              out_valid,
	output logic [RW-1:0]     root [NUM_FACES],
	output logic [PW-1:0]     out_side
);

	logic [2*RW-1:0] rad_s  [RW][NUM_FACES];
	logic [RW+1:0]   rem_s  [RW][NUM_FACES];
	logic [RW-1:0]   root_s [RW][NUM_FACES];
	logic [PW-1:0]   side_s [RW];
	logic            vld_s  [RW];

	logic [2*RW-1:0] rad_nxt  [RW][NUM_FACES];
	logic [RW+1:0]   rem_nxt  [RW][NUM_FACES];
	logic [RW-1:0]   root_nxt [RW][NUM_FACES];

	// Each stage brings down two radicand bits and decides one root bit
	always_comb begin
		logic [2*RW-1:0] cur_rad;
		logic [RW+1:0]   cur_rem;
		logic [RW-1:0]   cur_root;
		logic [RW+3:0]   part;
		logic [RW+3:0]   trial;
		logic            ge;
		for (int j = 0; j < RW; j++) begin
			for (int f = 0; f < NUM_FACES; f++) begin
				if (j == 0) begin
					cur_rad  = radicand[f];
					cur_rem  = '0;
					cur_root = '0;
				end else begin
					cur_rad  = rad_s[j-1][f];
					cur_rem  = rem_s[j-1][f];
					cur_root = root_s[j-1][f];
				end
				part  = {cur_rem, cur_rad[2*RW-1 -: 2]};
				trial = {2'b00, cur_root, 2'b01};
				ge    = (part >= trial);
				rad_nxt[j][f]  = cur_rad << 2;
				rem_nxt[j][f]  = ge ? (RW+2)'(part - trial) : part[RW+1:0];
				root_nxt[j][f] = {cur_root[RW-2:0], ge};
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < RW; j++) begin
				rad_s[j]  <= rad_nxt[j];
				rem_s[j]  <= rem_nxt[j];
				root_s[j] <= root_nxt[j];
				side_s[j] <= (j == 0) ? in_side : side_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < RW; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < RW; j++) begin
				vld_s[j] <= (j == 0) ? in_valid : vld_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_side  = side_s[RW-1];

endmodule

[sv/tir_div.sv]
// Pipelined restoring divider: radius = floor(det / sum), saturating, with degenerate flag.
module tir_div
	import tir_pkg::*;
#(
	parameter int DW = 102,
	parameter int SW = 69
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [DW-1:0]           det,
	input  logic [SW-1:0]           sum,
	output logic                    out_valid,
	output logic [RADIUS_WIDTH-1:0] radius,
	output logic                    degenerate
);

	localparam int DV = (DW > SW + RADIUS_WIDTH) ? DW : SW + RADIUS_WIDTH;
	localparam int NS = RADIUS_WIDTH;

	logic [DW-1:0] det_s0;
	logic [SW-1:0] sum_s0;
	logic          deg_s0;
	logic          sat_s0;
	logic          vld_s0;

	logic [DW-1:0]           rem_s [NS];
	logic [SW-1:0]           sum_s [NS];
	logic [RADIUS_WIDTH-1:0] quo_s [NS];
	logic                    deg_s [NS];
	logic                    sat_s [NS];
	logic                    vld_s [NS];

	logic [DW-1:0]           rem_nxt [NS];
	logic [RADIUS_WIDTH-1:0] quo_nxt [NS];

	// Entry: flag zero sum and overflowing quotient
	always_ff @(posedge clk) begin
		if (en) begin
			det_s0 <= det;
			sum_s0 <= sum;
			deg_s0 <= (sum == '0);
			sat_s0 <= (DV'(det) >= (DV'(sum) << RADIUS_WIDTH));
		end
	end

	// One quotient bit per stage, most significant first
	always_comb begin
		logic [DW-1:0]           cur_rem;
		logic [SW-1:0]           cur_sum;
		logic [RADIUS_WIDTH-1:0] cur_quo;
		logic [DV-1:0]           dvs;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				cur_rem = det_s0;
				cur_sum = sum_s0;
				cur_quo = '0;
			end else begin
				cur_rem = rem_s[i-1];
				cur_sum = sum_s[i-1];
				cur_quo = quo_s[i-1];
			end
			dvs = DV'(cur_sum) << (NS - 1 - i);
			if (DV'(cur_rem) >= dvs) begin
				rem_nxt[i] = DW'(DV'(cur_rem) - dvs);
				quo_nxt[i] = cur_quo | (RADIUS_WIDTH'(1) << (NS - 1 - i));
			end else begin
				rem_nxt[i] = cur_rem;
				quo_nxt[i] = cur_quo;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NS; i++) begin
				rem_s[i] <= rem_nxt[i];
				quo_s[i] <= quo_nxt[i];
				sum_s[i] <= (i == 0) ? sum_s0 : sum_s[(i == 0) ? 0 : i-1];
				deg_s[i] <= (i == 0) ? deg_s0 : deg_s[(i == 0) ? 0 : i-1];
				sat_s[i] <= (i == 0) ? sat_s0 : sat_s[(i == 0) ? 0 : i-1];
			end
			degenerate <= deg_s[NS-1];
			if (deg_s[NS-1]) begin
				radius <= '0;
			end else if (sat_s[NS-1]) begin
				radius <= '1;
			end else begin
				radius <= quo_s[NS-1];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0    <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < NS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s0    <= in_valid;
			out_valid <= vld_s[NS-1];
			for (int i = 0; i < NS; i++) begin
				vld_s[i] <= (i == 0) ? vld_s0 : vld_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> radius == '0)
		else $error("degenerate request with nonzero radius");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && !deg_s[NS-1] && !sat_s[NS-1] |-> DV'(rem_s[NS-1]) < DV'(sum_s[NS-1]))
		else $error("division remainder not below divisor");

	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && sum_s[NS-1] == '0 |-> deg_s[NS-1])
		else $error("zero face sum not flagged degenerate");

endmodule

[sv/tetrahedron_inradius_core.sv]
// Top level: streaming tetrahedron inradius, |det| / sum of face cross lengths.
//
// Takes one tetrahedron per cycle while no result waits on m_tready, and returns one
// radius per request, in order. The pipeline has seven stages of edge, cross-product,
// determinant and squared-length arithmetic, one stage per root bit in the four-lane
// square root (2*COORD_WIDTH + 3 bits), a face-sum stage, and a 32-stage restoring
// divider between an entry and an output register. The whole pipeline holds while a
// result waits on m_tready. Results are exact: square roots and the quotient round
// down, an overflowing radius saturates to all ones, and a zero face sum gives
// radius 0 with the degenerate flag set.
module tetrahedron_inradius_core
	import tir_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// radius
	output logic [RADIUS_WIDTH-1:0] m_tdata,
	// degenerate
	output logic m_tuser
);

	localparam int NC  = 12;
	localparam int NE  = 5;
	localparam int EW  = COORD_WIDTH + 1;
	localparam int XW  = 2*EW + 1;
	localparam int H   = (XW + 1) / 2;
	localparam int HW  = XW - H;
	localparam int DW  = EW + XW + 2;
	localparam int NW  = 2*XW;
	localparam int RW  = XW;
	localparam int SW  = RW + 2;
	localparam int PHW = EW + HW;
	localparam int PLW = EW + H + 1;

	// Edges: a1 = v1-v0, a2 = v2-v0, a3 = v3-v0, b1 = v2-v1, b2 = v3-v1
	localparam int EDGE_P [NE] = '{1, 2, 3, 2, 3};
	localparam int EDGE_Q [NE] = '{0, 0, 0, 1, 1};
	// Faces: a2 x a3 (also feeds the determinant), a1 x a2, a1 x a3, b1 x b2
	localparam int FACE_U [NUM_FACES] = '{1, 0, 0, 3};
	localparam int FACE_V [NUM_FACES] = '{2, 1, 2, 4};
	localparam int NEXT1 [3] = '{1, 2, 0};
	localparam int NEXT2 [3] = '{2, 0, 1};

	logic en;
	logic signed [COORD_WIDTH-1:0] crd [NC];

	logic signed [EW-1:0]   e_s1  [NE][3];
	logic signed [2*EW-1:0] pa_s2 [NUM_FACES][3];
	logic signed [2*EW-1:0] pb_s2 [NUM_FACES][3];
	logic signed [EW-1:0]   a1_s2 [3];
	logic signed [XW-1:0]   c_s3  [NUM_FACES][3];
	logic signed [EW-1:0]   a1_s3 [3];
	logic [XW-1:0]          mag_s4 [NUM_FACES][3];
	logic signed [PHW-1:0]  dph_s4 [3];
	logic signed [PLW-1:0]  dpl_s4 [3];
	logic [2*HW-1:0]        hh_s5 [NUM_FACES][3];
	logic [XW-1:0]          hl_s5 [NUM_FACES][3];
	logic [2*H-1:0]         ll_s5 [NUM_FACES][3];
	logic signed [DW-1:0]   det_s5;
	logic [NW-1:0]          sq_s6 [NUM_FACES][3];
	logic [DW-1:0]          adet_s6;
	logic [NW-1:0]          nsq_s7 [NUM_FACES];
	logic [DW-1:0]          adet_s7;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic                   sq_vld;
	logic [RW-1:0]          sq_root [NUM_FACES];
	logic [DW-1:0]          sq_det;
	logic [SW-1:0]          rsum_s8;
	logic [DW-1:0]          det_s8;
	logic                   vld_s8;

	// Hold the whole pipeline while a result waits
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Unpack coordinates
	always_comb begin
		for (int i = 0; i < NC; i++) begin
			crd[i] = $signed(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
		end
	end

	// Arithmetic stages up to the squared face lengths
	always_ff @(posedge clk) begin
		if (en) begin
			// Edge vectors
			for (int e = 0; e < NE; e++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[e][k] <= EW'(crd[EDGE_P[e]*3 + k]) - EW'(crd[EDGE_Q[e]*3 + k]);
				end
			end
			// Cross-product terms
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int k = 0; k < 3; k++) begin
					pa_s2[f][k] <= e_s1[FACE_U[f]][NEXT1[k]] * e_s1[FACE_V[f]][NEXT2[k]];
					pb_s2[f][k] <= e_s1[FACE_U[f]][NEXT2[k]] * e_s1[FACE_V[f]][NEXT1[k]];
				end
			end
			a1_s2 <= e_s1[0];
			// Cross-product components
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int k = 0; k < 3; k++) begin
					c_s3[f][k] <= XW'(pa_s2[f][k]) - XW'(pb_s2[f][k]);
				end
			end
			a1_s3 <= a1_s2;
			// Magnitudes and split determinant products
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int k = 0; k < 3; k++) begin
					mag_s4[f][k] <= c_s3[f][k][XW-1] ? XW'(-c_s3[f][k]) : XW'(c_s3[f][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				dph_s4[k] <= a1_s3[k] * $signed(c_s3[0][k][XW-1:H]);
				dpl_s4[k] <= a1_s3[k] * $signed({1'b0, c_s3[0][k][H-1:0]});
			end
			// Partial squares and determinant sum
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int k = 0; k < 3; k++) begin
					hh_s5[f][k] <= mag_s4[f][k][XW-1:H] * mag_s4[f][k][XW-1:H];
					hl_s5[f][k] <= mag_s4[f][k][XW-1:H] * mag_s4[f][k][H-1:0];
					ll_s5[f][k] <= mag_s4[f][k][H-1:0] * mag_s4[f][k][H-1:0];
				end
			end
			det_s5 <= ((DW'(dph_s4[0]) <<< H) + DW'(dpl_s4[0]))
				+ ((DW'(dph_s4[1]) <<< H) + DW'(dpl_s4[1]))
				+ ((DW'(dph_s4[2]) <<< H) + DW'(dpl_s4[2]));
			// Full squares and absolute determinant
			for (int f = 0; f < NUM_FACES; f++) begin
				for (int k = 0; k < 3; k++) begin
					sq_s6[f][k] <= (NW'(hh_s5[f][k]) << (2*H)) + (NW'(hl_s5[f][k]) << (H+1))
						+ NW'(ll_s5[f][k]);
				end
			end
			adet_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			// Squared face lengths
			for (int f = 0; f < NUM_FACES; f++) begin
				nsq_s7[f] <= sq_s6[f][0] + sq_s6[f][1] + sq_s6[f][2];
			end
			adet_s7 <= adet_s6;
			// Face length sum
			rsum_s8 <= SW'(sq_root[0]) + SW'(sq_root[1]) + SW'(sq_root[2]) + SW'(sq_root[3]);
			det_s8  <= sq_det;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= sq_vld;
		end
	end

	// Face lengths, determinant rides alongside
	tir_sqrt #(
		.RW (RW),
		.PW (DW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.radicand  (nsq_s7),
		.in_side   (adet_s7),
		.out_valid (sq_vld),
		.root      (sq_root),
		.out_side  (sq_det)
	);

	// Quotient with saturation and degenerate flag
	tir_div #(
		.DW (DW),
		.SW (SW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (vld_s8),
		.det        (det_s8),
		.sum        (rsum_s8),
		.out_valid  (m_tvalid),
		.radius     (m_tdata),
		.degenerate (m_tuser)
	);

endmodule

[dv/tb_tetrahedron_inradius_core.sv]
// Testbench for tetrahedron_inradius_core: random and directed tetrahedra checked against a predictor.
`timescale 1ns / 1ps

module tb_tetrahedron_inradius_core;
	import tir_pkg::*;

	localparam int CW = 32;
	localparam int DW = ((12*CW+7)/8)*8;
	localparam int LATENCY = 2*CW + 45;

	typedef logic signed [255:0] wide_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [RADIUS_WIDTH-1:0] m_tdata;
	logic m_tuser;

	logic [DW-1:0] pending_tets[$];
	logic [RADIUS_WIDTH:0] expected_radii[$];
	int errors;
	int tets_taken;
	int radii_seen;
	logic in_taken;
	logic out_taken;
	int send_wait;
	int recv_wait;
	int recv_draw;
	int hold_cnt;
	bit hold_done;
	bit stim_done;

	tetrahedron_inradius_core #(.COORD_WIDTH(CW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// floor of the length of u x v
	function automatic wide_t face_len(wide_t ux, wide_t uy, wide_t uz,
			wide_t vx, wide_t vy, wide_t vz);
		wide_t cx, cy, cz, n, r, t;
		wide_t one;
		one = 1;
		cx = uy*vz - uz*vy;
		cy = uz*vx - ux*vz;
		cz = ux*vy - uy*vx;
		n = cx*cx + cy*cy + cz*cz;
		r = 0;
		for (int b = 80; b >= 0; b--) begin
			t = r | (one << b);
			if (t*t <= n)
				r = t;
		end
		return r;
	endfunction

	// {degenerate, radius} for one packed tetrahedron
	function automatic logic [RADIUS_WIDTH:0] inradius_of(logic [DW-1:0] d);
		logic signed [CW-1:0] c;
		wide_t p[12];
		wide_t a1x, a1y, a1z, a2x, a2y, a2z, a3x, a3y, a3z;
		wide_t b1x, b1y, b1z, b2x, b2y, b2z;
		wide_t det, s, q;
		for (int i = 0; i < 12; i++) begin
			c = d[CW*i +: CW];
			p[i] = c;
		end
		a1x = p[3] - p[0]; a1y = p[4] - p[1]; a1z = p[5] - p[2];
		a2x = p[6] - p[0]; a2y = p[7] - p[1]; a2z = p[8] - p[2];
		a3x = p[9] - p[0]; a3y = p[10] - p[1]; a3z = p[11] - p[2];
		b1x = p[6] - p[3]; b1y = p[7] - p[4]; b1z = p[8] - p[5];
		b2x = p[9] - p[3]; b2y = p[10] - p[4]; b2z = p[11] - p[5];
		det = a1x*(a2y*a3z - a2z*a3y) + a1y*(a2z*a3x - a2x*a3z)
			+ a1z*(a2x*a3y - a2y*a3x);
		if (det < 0)
			det = -det;
		s = face_len(a2x, a2y, a2z, a3x, a3y, a3z) + face_len(a1x, a1y, a1z, a2x, a2y, a2z)
			+ face_len(a1x, a1y, a1z, a3x, a3y, a3z)
			+ face_len(b1x, b1y, b1z, b2x, b2y, b2z);
		if (s == 0)
			return {1'b1, {RADIUS_WIDTH{1'b0}}};
		if (det >= (s <<< 32))
			return {1'b0, {RADIUS_WIDTH{1'b1}}};
		q = det / s;
		return {1'b0, q[RADIUS_WIDTH-1:0]};
	endfunction

	function automatic logic [DW-1:0] pack_tet(logic [CW-1:0] c[12]);
		logic [DW-1:0] d;
		d = '0;
		for (int i = 0; i < 12; i++)
			d[CW*i +: CW] = c[i];
		return d;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// drive requests from the pending queue
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			send_wait <= 0;
		end else if (s_tvalid && !in_taken) begin
			s_tvalid <= 1;
		end else if (send_wait > 0) begin
			s_tvalid <= 0;
			send_wait <= send_wait - 1;
		end else if (pending_tets.size() > 0) begin
			s_tdata <= pending_tets.pop_front();
			s_tvalid <= 1;
			send_wait <= ((tets_taken / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
		end else begin
			s_tvalid <= 0;
		end
	end

	// drive m_tready, with one long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			recv_wait <= 0;
			hold_cnt <= 0;
			hold_done <= 0;
		end else if (!hold_done && tets_taken >= 150) begin
			m_tready <= 0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= 3*LATENCY)
				hold_done <= 1;
		end else if (out_taken && (radii_seen / 100) % 3 != 2) begin
			recv_draw = $urandom_range(0, 4);
			recv_wait <= (recv_draw > 0) ? recv_draw - 1 : 0;
			m_tready <= (recv_draw == 0);
		end else if (recv_wait > 0) begin
			m_tready <= 0;
			recv_wait <= recv_wait - 1;
		end else begin
			m_tready <= 1;
		end
	end

	// predict on accepted requests, check accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 0;
			out_taken <= 0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				expected_radii.push_back(inradius_of(s_tdata));
				tets_taken <= tets_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				radii_seen <= radii_seen + 1;
				if (expected_radii.size() == 0) begin
					$display("%0t: unexpected result radius=%h degenerate=%b",
						$time, m_tdata, m_tuser);
					errors <= errors + 1;
				end else begin
					logic [RADIUS_WIDTH:0] e;
					e = expected_radii.pop_front();
					if (e[RADIUS_WIDTH-1:0] !== m_tdata) begin
						$display("%0t: radius mismatch expected=%h actual=%h",
							$time, e[RADIUS_WIDTH-1:0], m_tdata);
					end
					if (e[RADIUS_WIDTH] !== m_tuser) begin
						$display("%0t: degenerate mismatch expected=%b actual=%b",
							$time, e[RADIUS_WIDTH], m_tuser);
					end
					if (e[RADIUS_WIDTH-1:0] !== m_tdata || e[RADIUS_WIDTH] !== m_tuser)
						errors <= errors + 1;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [CW-1:0] c[12];
		int kind;
		int sc;
		errors = 0;
		tets_taken = 0;
		radii_seen = 0;
		stim_done = 0;

		// degenerate: all points equal
		for (int i = 0; i < 12; i++) c[i] = 0;
		pending_tets.push_back(pack_tet(c));
		for (int i = 0; i < 12; i++) c[i] = 32'h7FFF_FFFF;
		pending_tets.push_back(pack_tet(c));
		// collinear points
		for (int i = 0; i < 4; i++) begin
			c[3*i] = i * 32'h0001_0000; c[3*i+1] = 0; c[3*i+2] = 0;
		end
		pending_tets.push_back(pack_tet(c));
		// unit corner tetrahedron and its mirror
		c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		pending_tets.push_back(pack_tet(c));
		c = '{0, 0, 0, -32'sh10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		pending_tets.push_back(pack_tet(c));
		// flat: fourth point in the plane of the others
		c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 32'h30000, 32'h20000, 0};
		pending_tets.push_back(pack_tet(c));
		// extreme corners of the coordinate range
		c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
		pending_tets.push_back(pack_tet(c));
		c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
		pending_tets.push_back(pack_tet(c));
		// smallest nonzero steps
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
		pending_tets.push_back(pack_tet(c));
		c = '{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1};
		pending_tets.push_back(pack_tet(c));
		// two coincident vertices
		c = '{5, 6, 7, 5, 6, 7, 32'h20000, 3, 9, 1, 32'h40000, 2};
		pending_tets.push_back(pack_tet(c));
		for (int i = 0; i < 12; i++) c[i] = 32'hAAAA_AAAA ^ (i[0] ? 32'hFFFF_FFFF : 0);
		pending_tets.push_back(pack_tet(c));

		// random tetrahedra of several shapes
		for (int n = 0; n < 550; n++) begin
			kind = $urandom_range(0, 9);
			sc = $urandom_range(4, 31);
			for (int i = 0; i < 12; i++) begin
				if (kind < 4)
					c[i] = $urandom();
				else
					c[i] = $signed($urandom()) >>> (31 - sc);
			end
			if (kind == 8) begin
				// fourth vertex on the plane of the first three
				for (int k = 0; k < 3; k++)
					c[9+k] = c[3+k] + c[6+k] - c[k];
			end else if (kind == 9) begin
				// repeat one vertex
				for (int k = 0; k < 3; k++)
					c[9+k] = c[$urandom_range(0, 2)*3+k];
			end
			pending_tets.push_back(pack_tet(c));
		end

		wait (pending_tets.size() == 0);
		@(posedge clk);
		wait (!s_tvalid);
		wait (expected_radii.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_radii.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
